FILE: src/mds_pkg.sv
// Shared types and constants of the mean and deviation statistics block.
// No dependencies; used by the top level and by the checker.
`default_nettype none
package mds_pkg;
   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int SAMPLE_W        = 24;
   localparam int COUNT_OUT_W     = 11;
   localparam int RELEVANCE_W     = 26;
   localparam int DEV_W           = SAMPLE_W + 1;
   localparam int ROOT_W          = DEV_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_PASS,
      ST_ABS_GO,
      ST_ABS_WAIT,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT
   } state_type;
endpackage
`default_nettype wire

FILE: src/mean_deviation_statistics.sv
// Top level: sample store, running sum, deviation pass and result sequencer;
// uses mds_pkg, mds_divider and mds_sqrt. A sample without last is stored and leaves the block idle.
// A last sample holds busy through three divides (mean, absolute deviation and
// squared deviation), a pass over the N stored samples and a square root.
// The result strobes in the same cycle in which busy falls; the receiver cannot
// stall. Reset clears counts, sum and flags.
`default_nettype none
module mean_deviation_statistics #(
   parameter int MAX_SAMPLES = mds_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [mds_pkg::SAMPLE_W-1:0]   req_sample,
   input  wire logic                                  req_last,
   output logic                                       rsp_valid,
   output logic signed [mds_pkg::SAMPLE_W-1:0]        rsp_mean,
   output logic [mds_pkg::SAMPLE_W-1:0]               rsp_std_dev,
   output logic [mds_pkg::SAMPLE_W-1:0]               rsp_abs_dev,
   output logic signed [mds_pkg::RELEVANCE_W-1:0]     rsp_relevance,
   output logic [mds_pkg::COUNT_OUT_W-1:0]            rsp_sample_count,
   output logic                                       rsp_overflow
);
   localparam int SW   = mds_pkg::SAMPLE_W;
   localparam int DW   = mds_pkg::DEV_W;
   localparam int RW   = mds_pkg::ROOT_W;
   localparam int AW   = $clog2(MAX_SAMPLES);
   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int SUMW = SW + CW;
   localparam int ABSW = DW + CW;
   localparam int SQW  = 2 * DW + CW;

   mds_pkg::state_type state_ff, state_in;

   logic signed [SW-1:0]   store_mem [MAX_SAMPLES];
   logic signed [SW-1:0]   rd_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          idx_ff;
   logic signed [SUMW-1:0] sum_ff;
   logic                   drop_ff;
   logic signed [SW-1:0]   mean_ff;
   logic [DW-1:0]          a_ff;
   logic [2*DW-1:0]        prod_ff;
   logic                   v1_ff, v2_ff, v3_ff;
   logic [ABSW-1:0]        abs_sum_ff;
   logic [SQW-1:0]         sq_sum_ff;
   logic [SW-1:0]          abs_dev_ff;
   logic [2*RW-1:0]        msd_ff;

   logic                   rsp_valid_ff;
   logic signed [SW-1:0]   rsp_mean_ff;
   logic [SW-1:0]          rsp_std_ff;
   logic [SW-1:0]          rsp_abs_ff;
   logic signed [mds_pkg::RELEVANCE_W-1:0] rsp_rel_ff;
   logic [mds_pkg::COUNT_OUT_W-1:0] rsp_cnt_ff;
   logic                   rsp_ovf_ff;

   logic                   accept;
   logic                   room;
   logic                   issue;
   logic                   div_start, div_done;
   logic [SQW-1:0]         div_dividend;
   logic [SQW-1:0]         div_quot;
   logic                   sq_start, sq_done;
   logic [RW-1:0]          sq_root;
   logic [SUMW-1:0]        sum_mag;
   logic signed [SW-1:0]   q_mean;
   logic signed [DW:0]     diff;
   logic [SW-1:0]          std_val;

   assign busy   = state_ff != mds_pkg::ST_IDLE;
   assign accept = start && !busy;
   assign room   = count_ff < CW'(MAX_SAMPLES);
   assign issue  = (state_ff == mds_pkg::ST_PASS) && (idx_ff < count_ff);

   always_comb begin
      sum_mag = sum_ff[SUMW-1] ? SUMW'(-sum_ff) : SUMW'(sum_ff);
      q_mean  = SW'(div_quot);
      diff    = (DW+1)'(rd_ff) - (DW+1)'(mean_ff);
      std_val = SW'(sq_root);
   end

   always_comb begin
      unique case (state_ff)
         mds_pkg::ST_ABS_GO: div_dividend = SQW'(abs_sum_ff);
         mds_pkg::ST_SQ_GO:  div_dividend = sq_sum_ff;
         default:            div_dividend = SQW'(sum_mag);
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      sq_start  = 1'b0;
      unique case (state_ff)
         mds_pkg::ST_IDLE:
            if (accept && req_last) state_in = mds_pkg::ST_MEAN_GO;
         mds_pkg::ST_MEAN_GO: begin
            div_start = 1'b1;
            state_in  = mds_pkg::ST_MEAN_WAIT;
         end
         mds_pkg::ST_MEAN_WAIT:
            if (div_done) state_in = mds_pkg::ST_PASS;
         mds_pkg::ST_PASS:
            if (!issue && !v1_ff && !v2_ff && !v3_ff) state_in = mds_pkg::ST_ABS_GO;
         mds_pkg::ST_ABS_GO: begin
            div_start = 1'b1;
            state_in  = mds_pkg::ST_ABS_WAIT;
         end
         mds_pkg::ST_ABS_WAIT:
            if (div_done) state_in = mds_pkg::ST_SQ_GO;
         mds_pkg::ST_SQ_GO: begin
            div_start = 1'b1;
            state_in  = mds_pkg::ST_SQ_WAIT;
         end
         mds_pkg::ST_SQ_WAIT:
            if (div_done) state_in = mds_pkg::ST_ROOT_GO;
         mds_pkg::ST_ROOT_GO: begin
            sq_start = 1'b1;
            state_in = mds_pkg::ST_ROOT_WAIT;
         end
         mds_pkg::ST_ROOT_WAIT:
            if (sq_done) state_in = mds_pkg::ST_IDLE;
         default: state_in = mds_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mds_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (accept && room) store_mem[count_ff[AW-1:0]] <= req_sample;
      if (issue) rd_ff <= store_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         drop_ff      <= 1'b0;
         idx_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (accept) begin
            if (room) begin
               count_ff <= count_ff + CW'(1);
               sum_ff   <= sum_ff + SUMW'(req_sample);
            end else begin
               drop_ff <= 1'b1;
            end
         end
         if (state_ff == mds_pkg::ST_MEAN_WAIT && div_done) begin
            // The divider works on magnitudes; restore the sign of the sum.
            mean_ff    <= sum_ff[SUMW-1] ? -q_mean : q_mean;
            idx_ff     <= '0;
            abs_sum_ff <= '0;
            sq_sum_ff  <= '0;
         end
         if (issue) idx_ff <= idx_ff + CW'(1);
         if (v1_ff) a_ff <= diff[DW] ? DW'(-diff) : DW'(diff);
         if (v2_ff) begin
            prod_ff    <= a_ff * a_ff;
            abs_sum_ff <= abs_sum_ff + ABSW'(a_ff);
         end
         if (v3_ff) sq_sum_ff <= sq_sum_ff + SQW'(prod_ff);
         if (state_ff == mds_pkg::ST_ABS_WAIT && div_done) abs_dev_ff <= SW'(div_quot);
         if (state_ff == mds_pkg::ST_SQ_WAIT && div_done) msd_ff <= (2*RW)'(div_quot);
         if (state_ff == mds_pkg::ST_ROOT_WAIT && sq_done) begin
            rsp_valid_ff <= 1'b1;
            rsp_mean_ff  <= mean_ff;
            rsp_std_ff   <= std_val;
            rsp_abs_ff   <= abs_dev_ff;
            rsp_rel_ff   <= mds_pkg::RELEVANCE_W'(mean_ff)
                          - mds_pkg::RELEVANCE_W'({1'b0, std_val});
            rsp_cnt_ff   <= mds_pkg::COUNT_OUT_W'(count_ff);
            rsp_ovf_ff   <= drop_ff;
            count_ff     <= '0;
            sum_ff       <= '0;
            drop_ff      <= 1'b0;
         end
      end
   end

   mds_divider #(.W(SQW), .D(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   mds_sqrt #(.RW(RW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (msd_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean         = rsp_mean_ff;
   assign rsp_std_dev      = rsp_std_ff;
   assign rsp_abs_dev      = rsp_abs_ff;
   assign rsp_relevance    = rsp_rel_ff;
   assign rsp_sample_count = rsp_cnt_ff;
   assign rsp_overflow     = rsp_ovf_ff;
endmodule
`default_nettype wire

FILE: src/mds_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by the three divides of the sequencer.
`default_nettype none
module mds_divider #(
   parameter int W = 64,
   parameter int D = 11
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [D-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient
);
   localparam int CNTW = $clog2(W + 1);

   logic [W-1:0]    quot_ff;
   logic [D-1:0]    rem_ff;
   logic [D-1:0]    div_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            run_ff;
   logic            done_ff;
   logic [D:0]      rem_sh;
   logic            ge;
   logic [D:0]      rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[W-1]};
      ge      = rem_sh >= {1'b0, div_ff};
      rem_sub = rem_sh - {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= CNTW'(W);
            quot_ff <= dividend;
            div_ff  <= divisor;
            rem_ff  <= '0;
         end else if (run_ff) begin
            rem_ff  <= ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
            quot_ff <= {quot_ff[W-2:0], ge};
            cnt_ff  <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

FILE: src/mds_sqrt.sv
// Iterative floor square root, one root bit per cycle.
// Depends on nothing; the top level hands it the mean squared deviation.
`default_nettype none
module mds_sqrt #(
   parameter int RW = 25
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [2*RW-1:0] radicand,
   output logic                 done,
   output logic [RW-1:0]        root
);
   localparam int CNTW = $clog2(RW + 1);

   logic [2*RW-1:0] rad_ff;
   logic [RW-1:0]   root_ff;
   logic [RW:0]     rem_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            run_ff;
   logic            done_ff;
   logic [RW+2:0]   rem_sh;
   logic [RW+2:0]   trial;
   logic            ge;
   logic [RW+2:0]   rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[2*RW-1:2*RW-2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = rem_sh >= trial;
      rem_sub = rem_sh - trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= CNTW'(RW);
            rad_ff  <= radicand;
            root_ff <= '0;
            rem_ff  <= '0;
         end else if (run_ff) begin
            rem_ff  <= ge ? rem_sub[RW:0] : rem_sh[RW:0];
            root_ff <= {root_ff[RW-2:0], ge};
            rad_ff  <= {rad_ff[2*RW-3:0], 2'b00};
            cnt_ff  <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

FILE: src/mds_checker.sv
// Port-level checks of the statistics block, bound to its top level.
// Depends on mds_pkg and mean_deviation_statistics.
`default_nettype none
module mds_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  start,
   input wire logic                                  busy,
   input wire logic                                  req_last,
   input wire logic                                  rsp_valid,
   input wire logic signed [mds_pkg::SAMPLE_W-1:0]   rsp_mean,
   input wire logic [mds_pkg::SAMPLE_W-1:0]          rsp_std_dev,
   input wire logic signed [mds_pkg::RELEVANCE_W-1:0] rsp_relevance
);
   // A result closes the computation, so the block is free again.
   a_free_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy while a result is shown");

   a_plain_one_cycle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last |=> !busy && !rsp_valid)
      else $error("a plain sample did not complete in one cycle");

   a_last_starts_work: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last |=> busy)
      else $error("a last sample did not start the computation");

   a_relevance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_relevance == mds_pkg::RELEVANCE_W'(rsp_mean)
         - mds_pkg::RELEVANCE_W'({1'b0, rsp_std_dev}))
      else $error("relevance does not match mean and deviation");
endmodule

bind mean_deviation_statistics mds_checker u_mds_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_mean         (rsp_mean),
   .rsp_std_dev      (rsp_std_dev),
   .rsp_relevance    (rsp_relevance)
);
`default_nettype wire
